// ===== design/lss_pkg.sv =====
// Shared types and constants for the link safety supervisor.
`default_nettype none

package lss_pkg;

   // Width of a source number
   localparam int SRC_ID_BITS = 8;

   // Health flags whose value 1 means the check passed; the others fail when set
   localparam logic [8:0] HEALTH_OK_MASK = 9'h13F;

   // Health flag positions with special handling
   localparam int HEALTH_INVARIANT_BIT = 0;
   localparam int HEALTH_QOS_BIT       = 8;

   // Recovery evidence counter
   localparam logic [15:0] SAMPLE_COUNT_MAX = 16'hFFFF;

   // Link states
   typedef enum logic [2:0] {
      ST_STANDBY    = 3'd0,
      ST_ACTIVE     = 3'd1,
      ST_RECOVERING = 3'd2,
      ST_DEGRADED   = 3'd3,
      ST_SAFESTOP   = 3'd4,
      ST_ERROR      = 3'd5
   } link_state_type;

   // State reasons
   localparam logic [3:0] RS_NONE      = 4'd0;
   localparam logic [3:0] RS_INVARIANT = 4'd1;
   localparam logic [3:0] RS_QOS       = 4'd9;
   localparam logic [3:0] RS_NO_SOURCE = 4'd10;
   localparam logic [3:0] RS_FIRST     = 4'd11;
   localparam logic [3:0] RS_SWITCH    = 4'd12;
   localparam logic [3:0] RS_FALLBACK  = 4'd13;
   localparam logic [3:0] RS_RECOVERED = 4'd14;

   // Arbitration events
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_FIRST    = 3'd1;
   localparam logic [2:0] EV_SWITCH   = 3'd2;
   localparam logic [2:0] EV_FALLBACK = 3'd3;

   // Item kinds
   localparam logic MODE_HEADER = 1'b0;

   // Decision pending for the current tick
   typedef enum logic [1:0] {
      BR_NONE     = 2'd0,
      BR_FIXED    = 2'd1,
      BR_RECOVERY = 2'd2
   } branch_type;

   // Input transaction
   typedef struct packed {
      logic                   mode;
      logic                   closes_tick;
      logic [8:0]             health_flags;
      logic                   source_present;
      logic [SRC_ID_BITS-1:0] src_id;
      logic [31:0]            generation;
      logic [2:0]             arbitration_event;
      logic [31:0]            epoch;
      logic                   evidence_accepted;
   } req_data_type;

   // Result transaction
   typedef struct packed {
      logic [2:0]             link_state;
      logic [3:0]             state_reason;
      logic                   out_source_present;
      logic [SRC_ID_BITS-1:0] out_source_id;
      logic [15:0]            recovery_count;
      logic [31:0]            transition_count;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== design/link_safety_supervisor.sv =====
// Link safety supervisor: per-tick link state decision with recovery counting.
//
//  channel | direction | handshake                    | payload
//  req     | in        | req_valid / req_ready        | req_data (header or evidence)
//  rsp     | out       | rsp_valid / rsp_ready        | rsp_data (one decision per tick)
//  csr     | in        | csr_write_enable, no wait    | csr_write_data (recovery threshold)
//
// One transaction per cycle sustained while results are taken. An accepted item waits in the
// input register while it is evaluated against the supervisor state; a closing item's decision
// enters the result register as it is evaluated, so rsp_valid rises behind the input register.
// The state update loop (flag priority, compares, counter) closes through the supervisor state.
// Reset is synchronous and clears all supervisor state; the threshold returns to 5.
// A full result register that is not taken holds the input register; req_ready drops at once.
`default_nettype none

module link_safety_supervisor
   import lss_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_data_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_data_type      rsp_data,
   input  wire logic         csr_write_enable,
   input  wire logic [15:0]  csr_write_data
);

   // Configuration
   logic [15:0] threshold_ff;

   // Input register
   logic         s1_valid_ff;
   req_data_type s1_data_ff;
   logic         s1_fire;

   // Result register
   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;
   logic         rsp_load;

   // Supervisor state
   link_state_type         cur_state_ff,    cur_state_in;
   logic [3:0]             cur_reason_ff,   cur_reason_in;
   logic                   last_valid_ff,   last_valid_in;
   logic [SRC_ID_BITS-1:0] last_source_ff,  last_source_in;
   logic [31:0]            transitions_ff,  transitions_in;
   logic                   cand_valid_ff,   cand_valid_in;
   logic [SRC_ID_BITS-1:0] cand_source_ff,  cand_source_in;
   logic [31:0]            cand_gen_ff,     cand_gen_in;
   logic [15:0]            samples_ff,      samples_in;
   logic                   epoch_valid_ff,  epoch_valid_in;
   logic [31:0]            epoch_seen_ff,   epoch_seen_in;
   branch_type             pend_branch_ff,  pend_branch_in;
   link_state_type         pend_state_ff,   pend_state_in;
   logic [3:0]             pend_reason_ff,  pend_reason_in;
   logic [31:0]            tick_epoch_ff,   tick_epoch_in;
   logic                   tick_present_ff, tick_present_in;
   logic [SRC_ID_BITS-1:0] tick_id_ff,      tick_id_in;

   // Health assessment of the registered item
   logic [8:0] health_fail;
   logic       hard_fail;
   logic [3:0] hard_index;

   // Stage control: evaluate when the result register can take a transaction
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Find the first failing check among the state-forcing flags
   assign health_fail = s1_data_ff.health_flags ^ HEALTH_OK_MASK;
   assign hard_fail   = |health_fail[HEALTH_QOS_BIT-1:0];

   always_comb begin
      hard_index = 4'd0;
      for (int i = HEALTH_QOS_BIT - 1; i >= 0; i--) begin
         if (health_fail[i]) begin
            hard_index = 4'(i);
         end
      end
   end

   // Evaluate one transaction against the supervisor state
   always_comb begin
      logic           changed;
      logic           cand_match;
      branch_type     branch_now;
      link_state_type commit_state;
      logic [3:0]     commit_reason;

      cur_state_in    = cur_state_ff;
      cur_reason_in   = cur_reason_ff;
      last_valid_in   = last_valid_ff;
      last_source_in  = last_source_ff;
      transitions_in  = transitions_ff;
      cand_valid_in   = cand_valid_ff;
      cand_source_in  = cand_source_ff;
      cand_gen_in     = cand_gen_ff;
      samples_in      = samples_ff;
      epoch_valid_in  = epoch_valid_ff;
      epoch_seen_in   = epoch_seen_ff;
      pend_branch_in  = pend_branch_ff;
      pend_state_in   = pend_state_ff;
      pend_reason_in  = pend_reason_ff;
      tick_epoch_in   = tick_epoch_ff;
      tick_present_in = tick_present_ff;
      tick_id_in      = tick_id_ff;
      rsp_load        = 1'b0;
      changed         = 1'b0;
      cand_match      = 1'b0;
      branch_now      = BR_NONE;
      commit_state    = ST_STANDBY;
      commit_reason   = RS_NONE;
      rsp_data_in     = rsp_data_ff;

      if (s1_fire) begin
         if (s1_data_ff.mode == MODE_HEADER) begin
            // Latch the tick's selection and epoch
            tick_present_in = s1_data_ff.source_present;
            tick_id_in      = s1_data_ff.source_present ? s1_data_ff.src_id
                                                        : '0;
            tick_epoch_in   = s1_data_ff.epoch;

            // Pick the pending decision by priority
            if (cur_state_ff == ST_ERROR) begin
               pend_branch_in = BR_FIXED;
               pend_state_in  = ST_ERROR;
               pend_reason_in = cur_reason_ff;
            end else if (hard_fail) begin
               pend_branch_in = BR_FIXED;
               pend_state_in  = (hard_index == 4'(HEALTH_INVARIANT_BIT)) ? ST_ERROR
                                                                         : ST_SAFESTOP;
               pend_reason_in = hard_index + 4'd1;
            end else if (!tick_present_in && cur_state_ff != ST_STANDBY) begin
               pend_branch_in = BR_FIXED;
               pend_state_in  = ST_SAFESTOP;
               pend_reason_in = RS_NO_SOURCE;
            end else if (health_fail[HEALTH_QOS_BIT]) begin
               pend_branch_in = BR_FIXED;
               pend_state_in  = ST_DEGRADED;
               pend_reason_in = RS_QOS;
            end else if (!tick_present_in) begin
               pend_branch_in = BR_FIXED;
               pend_state_in  = ST_STANDBY;
               pend_reason_in = cur_reason_ff;
            end else if (cur_state_ff == ST_ACTIVE) begin
               pend_branch_in = BR_FIXED;
               if (s1_data_ff.arbitration_event == EV_NONE) begin
                  pend_state_in  = ST_ACTIVE;
                  pend_reason_in = cur_reason_ff;
               end else if (s1_data_ff.arbitration_event == EV_SWITCH) begin
                  pend_state_in  = ST_ACTIVE;
                  pend_reason_in = RS_SWITCH;
               end else if (s1_data_ff.arbitration_event == EV_FALLBACK) begin
                  pend_state_in  = ST_ACTIVE;
                  pend_reason_in = RS_FALLBACK;
               end else begin
                  pend_state_in  = ST_ERROR;
                  pend_reason_in = RS_INVARIANT;
               end
            end else begin
               // Restart recovery on a new health epoch
               if (!epoch_valid_ff || epoch_seen_ff != tick_epoch_in) begin
                  epoch_valid_in = 1'b1;
                  epoch_seen_in  = tick_epoch_in;
                  cand_valid_in  = 1'b0;
                  samples_in     = '0;
               end
               if (s1_data_ff.arbitration_event > EV_FALLBACK) begin
                  pend_branch_in = BR_FIXED;
                  pend_state_in  = ST_ERROR;
                  pend_reason_in = RS_INVARIANT;
               end else begin
                  unique case (s1_data_ff.arbitration_event)
                     EV_FIRST:    pend_reason_in = RS_FIRST;
                     EV_SWITCH:   pend_reason_in = RS_SWITCH;
                     EV_FALLBACK: pend_reason_in = RS_FALLBACK;
                     default:     pend_reason_in = cur_reason_ff;
                  endcase
                  // Restart recovery on a new source or generation
                  if (!cand_valid_in || cand_source_ff != tick_id_in ||
                      cand_gen_ff != s1_data_ff.generation) begin
                     cand_valid_in  = 1'b1;
                     cand_source_in = tick_id_in;
                     cand_gen_in    = s1_data_ff.generation;
                     samples_in     = '0;
                  end
                  pend_branch_in = BR_RECOVERY;
                  pend_state_in  = ST_RECOVERING;
               end
            end
         end else begin
            // Count accepted evidence that matches the pending candidate and epoch; rejected evidence clears it
            cand_match = cand_valid_ff && cand_source_ff == s1_data_ff.src_id &&
                         cand_gen_ff == s1_data_ff.generation;
            if (pend_branch_ff == BR_RECOVERY && s1_data_ff.epoch == tick_epoch_ff &&
                cand_match) begin
               if (!s1_data_ff.evidence_accepted) begin
                  samples_in = '0;
               end else if (samples_ff != SAMPLE_COUNT_MAX) begin
                  samples_in = samples_ff + 16'd1;
               end
            end
         end

         // Close the tick and commit the pending decision
         if (s1_data_ff.closes_tick) begin
            branch_now     = pend_branch_in;
            pend_branch_in = BR_NONE;
            if (branch_now != BR_NONE) begin
               rsp_load = 1'b1;
               if (branch_now == BR_FIXED) begin
                  commit_state  = pend_state_in;
                  commit_reason = pend_reason_in;
               end else if (samples_in >= threshold_ff) begin
                  commit_state  = ST_ACTIVE;
                  commit_reason = RS_RECOVERED;
               end else begin
                  commit_state  = ST_RECOVERING;
                  commit_reason = pend_reason_in;
               end

               changed = cur_state_ff != commit_state || last_valid_ff != tick_present_in ||
                         (tick_present_in && last_source_ff != tick_id_in);
               if (changed) begin
                  cur_state_in   = commit_state;
                  cur_reason_in  = commit_reason;
                  last_valid_in  = tick_present_in;
                  last_source_in = tick_id_in;
                  transitions_in = transitions_ff + 32'd1;
               end
               if (commit_state != ST_RECOVERING) begin
                  cand_valid_in = 1'b0;
                  samples_in    = '0;
               end

               rsp_data_in.link_state         = cur_state_in;
               rsp_data_in.state_reason       = cur_reason_in;
               rsp_data_in.out_source_present = tick_present_in;
               rsp_data_in.out_source_id      = tick_id_in;
               rsp_data_in.recovery_count     = samples_in;
               rsp_data_in.transition_count   = transitions_in;
            end
         end
      end
   end

   // Hold the recovery threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 16'd5;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   // Advance the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Update supervisor state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff    <= ST_STANDBY;
         cur_reason_ff   <= RS_NONE;
         last_valid_ff   <= 1'b0;
         last_source_ff  <= '0;
         transitions_ff  <= '0;
         cand_valid_ff   <= 1'b0;
         cand_source_ff  <= '0;
         cand_gen_ff     <= '0;
         samples_ff      <= '0;
         epoch_valid_ff  <= 1'b0;
         epoch_seen_ff   <= '0;
         pend_branch_ff  <= BR_NONE;
         pend_state_ff   <= ST_STANDBY;
         pend_reason_ff  <= RS_NONE;
         tick_epoch_ff   <= '0;
         tick_present_ff <= 1'b0;
         tick_id_ff      <= '0;
      end else begin
         cur_state_ff    <= cur_state_in;
         cur_reason_ff   <= cur_reason_in;
         last_valid_ff   <= last_valid_in;
         last_source_ff  <= last_source_in;
         transitions_ff  <= transitions_in;
         cand_valid_ff   <= cand_valid_in;
         cand_source_ff  <= cand_source_in;
         cand_gen_ff     <= cand_gen_in;
         samples_ff      <= samples_in;
         epoch_valid_ff  <= epoch_valid_in;
         epoch_seen_ff   <= epoch_seen_in;
         pend_branch_ff  <= pend_branch_in;
         pend_state_ff   <= pend_state_in;
         pend_reason_ff  <= pend_reason_in;
         tick_epoch_ff   <= tick_epoch_in;
         tick_present_ff <= tick_present_in;
         tick_id_ff      <= tick_id_in;
      end
   end

   // Error is sticky
   assert property (@(posedge clock) disable iff (reset)
      cur_state_ff == ST_ERROR |=> cur_state_ff == ST_ERROR)
      else $error("left the error state");

   // Transition count moves only with a decision
   assert property (@(posedge clock) disable iff (reset)
      !rsp_load |=> $stable(transitions_ff))
      else $error("transition count changed without a decision");

   // A nonzero recovery count belongs to a live candidate
   assert property (@(posedge clock) disable iff (reset)
      samples_ff != 16'd0 |-> cand_valid_ff)
      else $error("recovery count without candidate");

   // Closing a tick clears the pending decision
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_data_ff.closes_tick |=> pend_branch_ff == BR_NONE)
      else $error("pending decision survived tick close");

endmodule

`default_nettype wire
